>>> design/sha_pkg.sv
// Shared types, constants and round functions for the SHA-256 message hasher.
`timescale 1ns / 1ps
package sha_pkg;

    typedef struct packed {
        logic [31:0] data_word;
        logic [2:0]  byte_count;
        logic        last_word;
    } t_in_item;

    typedef struct packed {
        logic [31:0] digest_word;
        logic        digest_last;
    } t_out_item;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam logic [31:0] INITIAL_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // Command from the sequencer to the round unit.
    typedef struct packed {
        logic       start;
        logic [5:0] round;
        logic       round_en;
        logic       fold;
    } t_rnd_ctl;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage

>>> design/sha_sched.sv
// Message schedule: 16-word sliding window that yields one W word per round.
`timescale 1ns / 1ps
module sha_sched (
    input  logic        i_clk,
    input  logic        i_load,
    input  logic [31:0] i_load_word,
    input  logic        i_shift,
    output logic [31:0] o_w
);
    import sha_pkg::*;

    logic [31:0] r_win [16];
    logic [31:0] w_new, s0, s1;

    assign o_w = r_win[0];
    assign s0  = rotr(r_win[1], 7) ^ rotr(r_win[1], 18) ^ (r_win[1] >> 3);
    assign s1  = rotr(r_win[14], 17) ^ rotr(r_win[14], 19) ^ (r_win[14] >> 10);
    assign w_new = r_win[0] + s0 + r_win[9] + s1;

    // Load words in at the tail; during rounds, advance and append the next W.
    always_ff @(posedge i_clk) begin
        if (i_load || i_shift) begin
            for (int k = 0; k < 15; k++) r_win[k] <= r_win[k + 1];
            r_win[15] <= i_load ? i_load_word : w_new;
        end
    end
endmodule

>>> design/sha_round.sv
// Shared SHA-256 round unit with the eight hash words and working registers.
`timescale 1ns / 1ps
module sha_round (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sha_pkg::t_rnd_ctl   i_ctl,
    input  logic [31:0]         i_w,
    input  logic                i_reinit,
    input  logic                i_hshift,
    output logic [31:0]         o_h0
);
    import sha_pkg::*;

    logic [31:0] r_h [8];
    logic [31:0] r_v [8];
    logic [31:0] t1, t2;

    assign t1 = r_v[7] + (rotr(r_v[4], 6) ^ rotr(r_v[4], 11) ^ rotr(r_v[4], 25))
              + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6])) + ROUND_K[i_ctl.round] + i_w;
    assign t2 = (rotr(r_v[0], 2) ^ rotr(r_v[0], 13) ^ rotr(r_v[0], 22))
              + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
    assign o_h0 = r_h[0];

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            for (int k = 0; k < 8; k++) r_v[k] <= r_h[k];
        end else if (i_ctl.round_en) begin
            r_v[0] <= t1 + t2;
            r_v[1] <= r_v[0];
            r_v[2] <= r_v[1];
            r_v[3] <= r_v[2];
            r_v[4] <= r_v[3] + t1;
            r_v[5] <= r_v[4];
            r_v[6] <= r_v[5];
            r_v[7] <= r_v[6];
        end
    end

    // Hash words: fold after the rounds, rotate out for the digest, reinit on reset and after.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_reinit) begin
            for (int k = 0; k < 8; k++) r_h[k] <= INITIAL_H[k];
        end else if (i_ctl.fold) begin
            for (int k = 0; k < 8; k++) r_h[k] <= r_h[k] + r_v[k];
        end else if (i_hshift) begin
            for (int k = 0; k < 7; k++) r_h[k] <= r_h[k + 1];
            r_h[7] <= r_h[0];
        end
    end
endmodule

>>> design/sha256_message_hasher.sv
// Top level of the SHA-256 message hasher: handshake, padding sequencer, digest out.
`timescale 1ns / 1ps
// Usage:
//   Input channel (i_in_valid / o_in_stall, payload i_in): one big-endian
//   message word per item. Only the item with last_word set may carry fewer
//   than four bytes (byte_count 0..4, leftmost bytes valid).
//   Output channel (o_out_valid / i_out_stall, payload o_out): eight digest
//   items H0..H7 after each last word, digest_last set on the eighth.
// Operation:
//   A word that closes a 16-word block is followed by 64 rounds of the
//   single shared round unit at one round per cycle plus a fold step; the
//   working registers load on the push cycle. A last word then feeds
//   padding and length words one per cycle outside the compressions,
//   running one or two more compressions before the first digest item.
//   The round unit bounds sustained throughput: the block takes no new
//   word until the current push, compression or digest is done.
// Reset: synchronous, active low; hash words return to the initial values,
//   counters clear, and the block is ready for a new message.
// Stall: while i_out_stall is high the current digest item holds; the block
//   takes no new input until all eight digest items are delivered.
module sha256_message_hasher (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  sha_pkg::t_in_item  i_in,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output sha_pkg::t_out_item o_out
);
    import sha_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PUSH  = 3'd1;  // one word into the window
    localparam logic [2:0] ST_RND   = 3'd2;  // 64 rounds
    localparam logic [2:0] ST_FOLD  = 3'd3;  // add working words into hash
    localparam logic [2:0] ST_OUT   = 3'd4;  // deliver digest

    logic [2:0]  r_state, n_state;
    logic [3:0]  r_pos, n_pos;
    logic [63:0] r_len, n_len;
    logic [5:0]  r_rnd, n_rnd;
    logic [2:0]  r_oidx, n_oidx;
    logic        r_last, n_last;     // padding sequence is running
    logic [1:0]  r_pend, n_pend;     // 1: data word then pad word queued
    logic [31:0] r_word, n_word;     // word queued for the window

    logic        in_acc, out_acc, load;
    logic [31:0] w, h0;
    t_rnd_ctl    ctl;
    logic        reinit, hshift;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_out_valid = (r_state == ST_OUT);
    assign out_acc     = o_out_valid && !i_out_stall;
    assign o_out.digest_word = h0;
    assign o_out.digest_last = (r_oidx == 3'd7);

    assign load        = (r_state == ST_PUSH);
    assign ctl.start   = (r_state == ST_PUSH) && (r_pos == 4'd15);
    assign ctl.round_en = (r_state == ST_RND);
    assign ctl.round   = r_rnd;
    assign ctl.fold    = (r_state == ST_FOLD);
    assign hshift      = out_acc;
    assign reinit      = out_acc && (r_oidx == 3'd7);

    sha_sched u_sched (
        .i_clk       (i_clk),
        .i_load      (load),
        .i_load_word (r_word),
        .i_shift     (ctl.round_en),
        .o_w         (w)
    );

    sha_round u_round (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (ctl),
        .i_w      (w),
        .i_reinit (reinit),
        .i_hshift (hshift),
        .o_h0     (h0)
    );

    // Sequencer: each pushed word goes through ST_PUSH; on the padding path the
    // next word is chosen when a push completes or a compression folds.
    always_comb begin
        logic [2:0] cnt;
        logic [5:0] shift;
        logic [31:0] keep;
        logic [3:0] npos;
        n_state = r_state;
        n_pos   = r_pos;
        n_len   = r_len;
        n_rnd   = r_rnd;
        n_oidx  = r_oidx;
        n_last  = r_last;
        n_pend  = r_pend;
        n_word  = r_word;
        cnt     = (i_in.byte_count > 3'd4) ? 3'd4 : i_in.byte_count;
        shift   = 6'd32 - {cnt, 3'b000};
        keep    = (cnt == 3'd0) ? 32'd0 : (32'hffffffff << shift);
        npos    = r_pos + 4'd1;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = ST_PUSH;
                    if (!i_in.last_word) begin
                        n_len  = r_len + 64'd32;
                        n_word = i_in.data_word;
                        n_last = 1'b0;
                        n_pend = 2'd0;
                    end else begin
                        n_len  = r_len + {58'd0, cnt, 3'b000};
                        n_last = 1'b1;
                        if (cnt == 3'd4) begin
                            n_word = i_in.data_word;
                            n_pend = 2'd1;
                        end else begin
                            n_word = (i_in.data_word & keep) |
                                     ({24'd0, PAD_BYTE} << (shift - 6'd8));
                            n_pend = 2'd0;
                        end
                    end
                end
            end
            ST_PUSH: begin
                n_pos = npos;
                if (r_pos == 4'd15) begin
                    n_state = ST_RND;
                    n_rnd   = 6'd0;
                end else if (!r_last) begin
                    n_state = ST_IDLE;
                end else begin
                    // Choose the next padding word for position npos.
                    if (r_pend == 2'd1) begin
                        n_word = {PAD_BYTE, 24'd0};
                        n_pend = 2'd0;
                    end else if (npos == 4'd14) begin
                        n_word = r_len[63:32];
                        n_pend = 2'd2;
                    end else if (r_pend == 2'd2) begin
                        n_word = r_len[31:0];
                        n_pend = 2'd3;
                    end else begin
                        n_word = 32'd0;
                    end
                end
            end
            ST_RND: begin
                n_rnd = r_rnd + 6'd1;
                if (r_rnd == 6'd63) n_state = ST_FOLD;
            end
            ST_FOLD: begin
                if (!r_last) begin
                    n_state = ST_IDLE;
                end else if (r_pend == 2'd3) begin
                    n_state = ST_OUT;
                    n_oidx  = 3'd0;
                end else begin
                    n_state = ST_PUSH;
                    if (r_pend == 2'd1) begin
                        n_word = {PAD_BYTE, 24'd0};
                        n_pend = 2'd0;
                    end else if (r_pend == 2'd2) begin
                        n_word = r_len[31:0];
                        n_pend = 2'd3;
                    end else begin
                        n_word = 32'd0;
                    end
                end
            end
            ST_OUT: begin
                if (out_acc) begin
                    n_oidx = r_oidx + 3'd1;
                    if (r_oidx == 3'd7) begin
                        n_state = ST_IDLE;
                        n_pos   = 4'd0;
                        n_len   = 64'd0;
                        n_last  = 1'b0;
                        n_pend  = 2'd0;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pos   <= 4'd0;
            r_len   <= 64'd0;
            r_rnd   <= 6'd0;
            r_oidx  <= 3'd0;
            r_last  <= 1'b0;
            r_pend  <= 2'd0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_len   <= n_len;
            r_rnd   <= n_rnd;
            r_oidx  <= n_oidx;
            r_last  <= n_last;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !in_acc) else $error("item taken while busy");
    a_rnd_to_fold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RND && r_rnd == 6'd63) |=> (r_state == ST_FOLD))
        else $error("round count overrun");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(r_oidx)))
        else $error("digest index moved under stall");
    a_done_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && o_out.digest_last) |=> (r_pos == 4'd0 && r_len == 64'd0))
        else $error("state not cleared after digest");
`endif
endmodule
